// ===== hw/rtl/binned_sum_and_hit_accumulator_assert.svh =====
// ----------------------------------------------------------------------------
// Binned sum and hit accumulator - assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BINNED_SUM_AND_HIT_ACCUMULATOR_ASSERT_SVH
`define BINNED_SUM_AND_HIT_ACCUMULATOR_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define BSHA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BSHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bsha_pkg.sv =====
// ----------------------------------------------------------------------------
// bsha_pkg
// Types, widths and codes shared by the binned sum and hit accumulator.
// ----------------------------------------------------------------------------
package bsha_pkg;

  // default sizing
  localparam int NUM_SIDEBANDS_DEF = 4;
  localparam int MAX_CHANNELS_DEF  = 64;
  localparam int MAX_BINS_DEF      = 1024;
  localparam int STORE_DEPTH_DEF   = 16384;

  // field widths
  localparam int SB_W    = 2;
  localparam int CH_W    = 6;
  localparam int PX_W    = 10;
  localparam int VAL_W   = 24;
  localparam int SUM_W   = 48;
  localparam int CNT_W   = 24;
  localparam int CHU_W   = 7;   // channels_in_use register
  localparam int BNU_W   = 11;  // bins_in_use register
  localparam int ROW_W   = 9;   // sideband*channels+channel, max 255
  localparam int FLAT_W  = 20;  // full flat address, max 262143
  localparam int ENTRY_W = SUM_W + CNT_W;

  // configuration port
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS     = 4'd1;

  // function codes
  localparam logic FUNC_ACCUM = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROW,
    ST_FLAT,
    ST_READ,
    ST_UPDATE
  } bsha_state_t;

  // controller to datapath
  typedef struct packed {
    logic in_ready;
    logic load_in;
    logic calc_row;
    logic calc_flat;
    logic mem_rd;
    logic mem_upd;
    logic load_out;
    logic clr_wr;
  } bsha_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic func_rd;
    logic out_busy;
  } bsha_status_t;

endpackage

// ===== hw/rtl/bsha_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsha_ctrl
// Sequencer: clearing pass, then accept, address, read, update per item.
// ----------------------------------------------------------------------------
`include "binned_sum_and_hit_accumulator_assert.svh"

module bsha_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  bsha_pkg::bsha_status_t st,
  output bsha_pkg::bsha_cmd_t    cmd
);
  import bsha_pkg::*;

  bsha_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (st.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_ROW;
      end
      ST_ROW:  state_nxt = ST_FLAT;
      ST_FLAT: state_nxt = ST_READ;
      ST_READ: state_nxt = ST_UPDATE;
      ST_UPDATE: begin
        // a read waits here until the output register is free
        if (!(st.func_rd && st.out_busy)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    case (state_r)
      ST_CLEAR: cmd.clr_wr = 1'b1;
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.load_in  = in_valid;
      end
      ST_ROW:  cmd.calc_row  = 1'b1;
      ST_FLAT: cmd.calc_flat = 1'b1;
      ST_READ: cmd.mem_rd    = 1'b1;
      ST_UPDATE: begin
        cmd.mem_upd  = !st.func_rd;
        cmd.load_out = st.func_rd && !st.out_busy;
      end
      default: cmd = '0;
    endcase
  end

  `BSHA_ASSERT_NEXT(a_accept_to_row, cmd.load_in, state_r == ST_ROW,
                    "accepted beat did not start address calculation")
  `BSHA_ASSERT_NEXT(a_read_holds, state_r == ST_UPDATE && st.func_rd && st.out_busy,
                    state_r == ST_UPDATE, "read result dropped while output busy")
  `BSHA_ASSERT_NEXT(a_clear_done, state_r == ST_CLEAR && st.clr_last,
                    state_r == ST_IDLE, "clearing pass did not end")

endmodule

// ===== hw/rtl/bsha_datapath.sv =====
// ----------------------------------------------------------------------------
// bsha_datapath
// Config registers, bin address, bin store, saturating update, output register.
// ----------------------------------------------------------------------------
`include "binned_sum_and_hit_accumulator_assert.svh"

module bsha_datapath #(
  parameter int NUM_SIDEBANDS = bsha_pkg::NUM_SIDEBANDS_DEF,
  parameter int MAX_CHANNELS  = bsha_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_BINS      = bsha_pkg::MAX_BINS_DEF,
  parameter int STORE_DEPTH   = bsha_pkg::STORE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  bsha_pkg::bsha_cmd_t                  cmd,
  output bsha_pkg::bsha_status_t               st,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bsha_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bsha_pkg::CFG_DAT_W-1:0]       cfg_data,
  input  logic                                 in_func,
  input  logic [bsha_pkg::SB_W-1:0]            in_sideband,
  input  logic [bsha_pkg::CH_W-1:0]            in_channel,
  input  logic [bsha_pkg::PX_W-1:0]            in_pixel_bin,
  input  logic signed [bsha_pkg::VAL_W-1:0]    in_sample_value,
  input  logic                                 in_sample_missing,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [bsha_pkg::SUM_W-1:0]    out_bin_sum,
  output logic [bsha_pkg::CNT_W-1:0]           out_bin_count,
  output logic                                 out_out_of_range
);
  import bsha_pkg::*;

  localparam int IDX_W  = $clog2(STORE_DEPTH);
  localparam int CH_RST = (MAX_CHANNELS < 64) ? MAX_CHANNELS : 64;
  localparam int BN_RST = (MAX_BINS < 1024) ? MAX_BINS : 1024;
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // configuration registers
  logic [CHU_W-1:0] chan_use_r, chan_use_nxt;
  logic [BNU_W-1:0] bins_use_r, bins_use_nxt;
  logic [CHU_W-1:0] cfg_ch_raw;
  logic [BNU_W-1:0] cfg_bn_raw;

  // item registers
  logic              func_r;
  logic [SB_W-1:0]   sb_r;
  logic [CH_W-1:0]   ch_r;
  logic [PX_W-1:0]   px_r;
  logic signed [VAL_W-1:0] val_r;
  logic              miss_r;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [FLAT_W-1:0] flat_r, flat_nxt;
  logic              addr_ok_r, addr_ok_nxt;

  // store
  logic [ENTRY_W-1:0] bin_mem [STORE_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [ENTRY_W-1:0] wr_data;
  logic [IDX_W-1:0]   wr_idx;
  logic               mem_we;
  logic [IDX_W-1:0]   clr_idx_r;

  // update arithmetic
  logic signed [SUM_W-1:0] rd_sum;
  logic [CNT_W-1:0]        rd_cnt;
  logic [SUM_W:0]          sum_ext;
  logic signed [SUM_W-1:0] sum_sat;
  logic signed [SUM_W-1:0] sum_new;
  logic [CNT_W-1:0]        cnt_new;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  logic signed [SUM_W-1:0] out_sum_r;
  logic [CNT_W-1:0]        out_cnt_r;
  logic                    out_oor_r;

  // configuration writes, clamped into range
  assign cfg_ready  = 1'b1;
  assign cfg_ch_raw = cfg_data[CHU_W-1:0];
  assign cfg_bn_raw = cfg_data[BNU_W-1:0];

  always_comb begin
    chan_use_nxt = chan_use_r;
    bins_use_nxt = bins_use_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_CHANNELS: begin
          if (cfg_ch_raw == '0)                     chan_use_nxt = CHU_W'(1);
          else if (32'(cfg_ch_raw) > MAX_CHANNELS)  chan_use_nxt = CHU_W'(MAX_CHANNELS);
          else                                      chan_use_nxt = cfg_ch_raw;
        end
        CFG_BINS: begin
          if (cfg_bn_raw == '0)                     bins_use_nxt = BNU_W'(1);
          else if (32'(cfg_bn_raw) > MAX_BINS)      bins_use_nxt = BNU_W'(MAX_BINS);
          else                                      bins_use_nxt = cfg_bn_raw;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_use_r <= CHU_W'(CH_RST);
      bins_use_r <= BNU_W'(BN_RST);
    end else begin
      chan_use_r <= chan_use_nxt;
      bins_use_r <= bins_use_nxt;
    end
  end

  // item capture and address stages
  assign row_nxt     = ROW_W'(sb_r) * ROW_W'(chan_use_r) + ROW_W'(ch_r);
  assign flat_nxt    = FLAT_W'(row_r) * FLAT_W'(bins_use_r) + FLAT_W'(px_r);
  assign addr_ok_nxt = (32'(sb_r) < NUM_SIDEBANDS) && (32'(flat_nxt) < STORE_DEPTH);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r <= in_func;
      sb_r   <= in_sideband;
      ch_r   <= in_channel;
      px_r   <= in_pixel_bin;
      val_r  <= in_sample_value;
      miss_r <= in_sample_missing;
    end
    if (cmd.calc_row) row_r <= row_nxt;
    if (cmd.calc_flat) begin
      flat_r    <= flat_nxt;
      addr_ok_r <= addr_ok_nxt;
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_idx_r <= clr_idx_r + IDX_W'(1);
    end
  end

  // saturating read-modify-write
  assign rd_sum  = rd_data_r[SUM_W-1:0];
  assign rd_cnt  = rd_data_r[ENTRY_W-1:SUM_W];
  assign sum_ext = {rd_sum[SUM_W-1], rd_sum}
                 + {{(SUM_W+1-VAL_W){val_r[VAL_W-1]}}, val_r};

  always_comb begin
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      sum_sat = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_ext[SUM_W-1:0];
    end
  end

  assign sum_new = miss_r ? rd_sum : sum_sat;
  assign cnt_new = (rd_cnt == '1) ? rd_cnt : rd_cnt + CNT_W'(1);

  assign mem_we  = cmd.clr_wr || (cmd.mem_upd && addr_ok_r);
  assign wr_idx  = cmd.clr_wr ? clr_idx_r : IDX_W'(flat_r);
  assign wr_data = cmd.clr_wr ? '0 : {cnt_new, sum_new};

  // bin store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) bin_mem[wr_idx] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) rd_data_r <= bin_mem[IDX_W'(flat_r)];
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.load_out)             out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_sum_r <= addr_ok_r ? rd_sum : '0;
      out_cnt_r <= addr_ok_r ? rd_cnt : '0;
      out_oor_r <= !addr_ok_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_bin_sum      = out_sum_r;
  assign out_bin_count    = out_cnt_r;
  assign out_out_of_range = out_oor_r;

  // status
  assign st.clr_last = (clr_idx_r == IDX_W'(STORE_DEPTH - 1));
  assign st.func_rd  = (func_r == FUNC_READ);
  assign st.out_busy = out_valid_r && !out_ready;

  `BSHA_ASSERT_SAME(a_load_free, cmd.load_out, !(out_valid_r && !out_ready),
                    "result loaded over a waiting beat")
  `BSHA_ASSERT_SAME(a_rise_loaded, $rose(out_valid_r), $past(cmd.load_out),
                    "output valid rose without a load")
  `BSHA_ASSERT_SAME(a_upd_accum, cmd.mem_upd, func_r == FUNC_ACCUM && !cmd.clr_wr,
                    "store update issued for a read item")

endmodule

// ===== hw/rtl/binned_sum_and_hit_accumulator.sv =====
// ----------------------------------------------------------------------------
// binned_sum_and_hit_accumulator
// Weighted histogram: per-bin saturating Q32.16 sums and hit counts.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per item. func 0 accumulates a sample into bin
//           (sideband*channels_in_use+channel)*bins_in_use+pixel_bin;
//           func 1 reads that bin. Accumulates produce no result.
//   out_* : one beat per read: sum, count and out_of_range.
//   cfg_* : register writes (0 channels_in_use, 1 bins_in_use), always
//           ready; values clamp to [1, max]. Write only while idle.
//   Each item goes through five steps: accept, two address multiply-add
//   steps, a registered store read, then the update write or result load.
//   A read result is loaded into the output register in its update step.
//   The sequencer takes each item through all five steps before it
//   accepts the next one.
//   Reset: the store is swept to zero one entry per cycle, all STORE_DEPTH
//   entries (16384 by default) with in_ready low; config is taken meanwhile.
//   Output stall: the result waits in the output register; a following
//   accumulate still proceeds, a following read waits for it to drain.
// ----------------------------------------------------------------------------
module binned_sum_and_hit_accumulator #(
  parameter int NUM_SIDEBANDS = bsha_pkg::NUM_SIDEBANDS_DEF,
  parameter int MAX_CHANNELS  = bsha_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_BINS      = bsha_pkg::MAX_BINS_DEF,
  parameter int STORE_DEPTH   = bsha_pkg::STORE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bsha_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bsha_pkg::CFG_DAT_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_func,
  input  logic [bsha_pkg::SB_W-1:0]            in_sideband,
  input  logic [bsha_pkg::CH_W-1:0]            in_channel,
  input  logic [bsha_pkg::PX_W-1:0]            in_pixel_bin,
  input  logic signed [bsha_pkg::VAL_W-1:0]    in_sample_value,
  input  logic                                 in_sample_missing,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [bsha_pkg::SUM_W-1:0]    out_bin_sum,
  output logic [bsha_pkg::CNT_W-1:0]           out_bin_count,
  output logic                                 out_out_of_range
);
  import bsha_pkg::*;

  bsha_cmd_t    cmd;
  bsha_status_t st;

  assign in_ready = cmd.in_ready;

  // sequencer
  bsha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath and bin store
  bsha_datapath #(
    .NUM_SIDEBANDS (NUM_SIDEBANDS),
    .MAX_CHANNELS  (MAX_CHANNELS),
    .MAX_BINS      (MAX_BINS),
    .STORE_DEPTH   (STORE_DEPTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_func           (in_func),
    .in_sideband       (in_sideband),
    .in_channel        (in_channel),
    .in_pixel_bin      (in_pixel_bin),
    .in_sample_value   (in_sample_value),
    .in_sample_missing (in_sample_missing),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_bin_sum       (out_bin_sum),
    .out_bin_count     (out_bin_count),
    .out_out_of_range  (out_out_of_range)
  );

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Binned sum and hit accumulator testbench
// Drives accumulate and read beats through the valid/ready input channel and
// keeps its own copy of the bin sums, hit counts and address registers. Every
// read result is checked field by field against that copy. Covers register
// clamping, bins at the edge of the store, missing samples, random idling on
// both sides and a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import bsha_pkg::*;

  localparam int unsigned RUN_LIMIT     = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;     // enough for a trailing item to finish
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned FIRST_UNUSED  = 2;     // lowest unknown register index
  localparam longint      SUM_HI        = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint      SUM_LO        = -SUM_HI - 1;

  typedef struct {
    logic                    func;
    logic [SB_W-1:0]         sideband;
    logic [CH_W-1:0]         channel;
    logic [PX_W-1:0]         pixel_bin;
    logic signed [VAL_W-1:0] sample_value;
    logic                    sample_missing;
  } bin_item_t;

  typedef struct {
    logic signed [SUM_W-1:0] bin_sum;
    logic [CNT_W-1:0]        bin_count;
    logic                    out_of_range;
  } bin_readout_t;

  // DUT signals
  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DAT_W-1:0]    cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    in_func = FUNC_ACCUM;
  logic [SB_W-1:0]         in_sideband = '0;
  logic [CH_W-1:0]         in_channel = '0;
  logic [PX_W-1:0]         in_pixel_bin = '0;
  logic signed [VAL_W-1:0] in_sample_value = '0;
  logic                    in_sample_missing = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [SUM_W-1:0] out_bin_sum;
  logic [CNT_W-1:0]        out_bin_count;
  logic                    out_out_of_range;

  // shadow of the bin stores and address registers
  logic signed [SUM_W-1:0] sum_bank [STORE_DEPTH_DEF];
  logic [CNT_W-1:0]        hit_bank [STORE_DEPTH_DEF];
  int unsigned             chan_cfg = MAX_CHANNELS_DEF;
  int unsigned             bins_cfg = MAX_BINS_DEF;
  bin_readout_t            expected_readouts [$];

  // run control and bookkeeping
  bit          src_no_idle = 1'b0;
  bit          sink_no_idle = 1'b0;
  bit          sink_long_hold = 1'b0;
  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  int unsigned reads_checked = 0;
  int unsigned oor_seen = 0;
  int unsigned cfg_writes = 0;
  int unsigned long_holds = 0;
  int unsigned cycle_count = 0;

  binned_sum_and_hit_accumulator u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_sideband       (in_sideband),
    .in_channel        (in_channel),
    .in_pixel_bin      (in_pixel_bin),
    .in_sample_value   (in_sample_value),
    .in_sample_missing (in_sample_missing),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_bin_sum       (out_bin_sum),
    .out_bin_count     (out_bin_count),
    .out_out_of_range  (out_out_of_range)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // shadow model
  // ---------------------------------------------------------------------------
  function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned flat_addr(bin_item_t b);
    return (b.sideband * chan_cfg + b.channel) * bins_cfg + b.pixel_bin;
  endfunction

  // update the shadow bins for one accepted beat, queue the readout of a read
  task automatic apply_to_bins(input bin_item_t it);
    int unsigned  a;
    bit           in_store;
    longint       acc;
    bin_readout_t r;
    a = flat_addr(it);
    in_store = (it.sideband < NUM_SIDEBANDS_DEF) && (a < STORE_DEPTH_DEF);
    if (it.func == FUNC_ACCUM) begin
      if (in_store) begin
        if (!it.sample_missing) begin
          acc = longint'(sum_bank[a]) + longint'(it.sample_value);
          if (acc > SUM_HI) acc = SUM_HI;
          if (acc < SUM_LO) acc = SUM_LO;
          sum_bank[a] = acc[SUM_W-1:0];
        end
        if (hit_bank[a] != '1) hit_bank[a] = hit_bank[a] + 1'b1;
      end
    end else begin
      if (in_store)
        r = '{bin_sum: sum_bank[a], bin_count: hit_bank[a], out_of_range: 1'b0};
      else
        r = '{bin_sum: '0, bin_count: '0, out_of_range: 1'b1};
      expected_readouts.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // drivers; all tasks are entered and left at a rising edge
  // ---------------------------------------------------------------------------
  function automatic bin_item_t mk_item(logic func, int unsigned sb, int unsigned ch,
                                        int unsigned px, logic [VAL_W-1:0] val,
                                        logic missing);
    bin_item_t b;
    b.func           = func;
    b.sideband       = SB_W'(sb);
    b.channel        = CH_W'(ch);
    b.pixel_bin      = PX_W'(px);
    b.sample_value   = val;
    b.sample_missing = missing;
    return b;
  endfunction

  // random bin inside the current register ranges, in the store when possible
  function automatic bin_item_t pick_bin();
    bin_item_t b;
    b = mk_item(FUNC_ACCUM, 0, 0, 0, '0, 1'b0);
    for (int tries = 0; tries < 8; tries++) begin
      b.sideband  = SB_W'($urandom_range(0, NUM_SIDEBANDS_DEF - 1));
      b.channel   = CH_W'($urandom_range(0, chan_cfg - 1));
      b.pixel_bin = PX_W'($urandom_range(0, bins_cfg - 1));
      if (flat_addr(b) < STORE_DEPTH_DEF) break;
    end
    return b;
  endfunction

  function automatic logic [VAL_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return {1'b0, {(VAL_W-1){1'b1}}};
      1:       return {1'b1, {(VAL_W-1){1'b0}}};
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // one input beat; valid stays high on return so a back-to-back beat follows
  task automatic offer_item(input bin_item_t it);
    int unsigned gap;
    gap = src_no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_func           <= it.func;
    in_sideband       <= it.sideband;
    in_channel        <= it.channel;
    in_pixel_bin      <= it.pixel_bin;
    in_sample_value   <= it.sample_value;
    in_sample_missing <= it.sample_missing;
    do @(negedge clk); while (in_ready !== 1'b1);
    apply_to_bins(it);
    items_sent++;
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_CHANNELS: chan_cfg = clamp_reg(32'(data[CHU_W-1:0]), MAX_CHANNELS_DEF);
      CFG_BINS:     bins_cfg = clamp_reg(32'(data[BNU_W-1:0]), MAX_BINS_DEF);
      default:      ;
    endcase
    cfg_writes++;
    @(posedge clk);
  endtask

  // both address registers plus a write to an index that does not exist
  task automatic apply_config(input logic [CFG_DAT_W-1:0] chan_data,
                              input logic [CFG_DAT_W-1:0] bins_data);
    write_reg(CFG_CHANNELS, chan_data);
    write_reg(CFG_IDX_W'($urandom_range(FIRST_UNUSED, 2**CFG_IDX_W - 1)),
              CFG_DAT_W'($urandom));
    write_reg(CFG_BINS, bins_data);
    cfg_valid <= 1'b0;
  endtask

  // drain all reads, then let a trailing accumulate leave the pipeline
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_readouts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result sink and checker
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned  stall;
    bin_readout_t want;
    @(posedge clk);
    forever begin
      if (sink_long_hold) begin
        stall = LONG_HOLD;
        sink_long_hold = 1'b0;
        long_holds++;
      end else begin
        stall = sink_no_idle ? 0 : $urandom_range(0, 12);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (out_valid !== 1'b1);
      if (expected_readouts.size() == 0) begin
        $error("unexpected result beat: bin_sum %0d bin_count %0d out_of_range %0b",
               out_bin_sum, out_bin_count, out_out_of_range);
        fail_count++;
      end else begin
        want = expected_readouts.pop_front();
        if (out_bin_sum !== want.bin_sum) begin
          $error("bin_sum: expected %0d, actual %0d", want.bin_sum, out_bin_sum);
          fail_count++;
        end
        if (out_bin_count !== want.bin_count) begin
          $error("bin_count: expected %0d, actual %0d", want.bin_count, out_bin_count);
          fail_count++;
        end
        if (out_out_of_range !== want.out_of_range) begin
          $error("out_of_range: expected %0b, actual %0b",
                 want.out_of_range, out_out_of_range);
          fail_count++;
        end
      end
      reads_checked++;
      if (out_out_of_range === 1'b1) oor_seen++;
      @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset register values, value extremes, missing samples, store boundary
  task automatic test_directed_corners();
    offer_item(mk_item(FUNC_READ,  0,  0,    0, '0,          1'b0)); // cleared bin
    offer_item(mk_item(FUNC_ACCUM, 0,  0,    0, 24'h7F_FFFF, 1'b0));
    offer_item(mk_item(FUNC_ACCUM, 0,  0,    0, 24'h80_0000, 1'b0));
    offer_item(mk_item(FUNC_ACCUM, 0,  0,    0, 24'h12_3456, 1'b1)); // value ignored
    offer_item(mk_item(FUNC_READ,  0,  0,    0, '0,          1'b0));
    offer_item(mk_item(FUNC_ACCUM, 3, 63, 1023, 24'h7F_FFFF, 1'b0)); // dropped
    offer_item(mk_item(FUNC_READ,  3, 63, 1023, 24'hFF_FFFF, 1'b1)); // flagged
    offer_item(mk_item(FUNC_ACCUM, 0, 15, 1023, 24'h00_0001, 1'b0)); // last entry
    offer_item(mk_item(FUNC_READ,  0, 15, 1023, '0,          1'b0));
    offer_item(mk_item(FUNC_READ,  0, 16,    0, '0,          1'b0)); // one past end
    offer_item(mk_item(FUNC_ACCUM, 0,  0,    5, 24'hFF_FFFF, 1'b1));
    offer_item(mk_item(FUNC_READ,  0,  0,    5, '0,          1'b0));
  endtask

  // zero and oversized writes clamp; channel and pixel past the registers
  task automatic test_register_clamping();
    wait_idle();
    apply_config('0, '0);
    offer_item(mk_item(FUNC_ACCUM, 3, 63, 1023, 24'h40_0000, 1'b0));
    offer_item(mk_item(FUNC_READ,  3, 63, 1023, '0,          1'b0));
    offer_item(mk_item(FUNC_READ,  2,  0,    0, '0,          1'b0));
    offer_item(mk_item(FUNC_READ,  0,  0,    0, '0,          1'b0));
    wait_idle();
    apply_config('1, '1);
    offer_item(mk_item(FUNC_READ,  0, 15, 1023, '0,          1'b0));
    wait_idle();
    apply_config(11'h040, 11'h401);
    offer_item(mk_item(FUNC_ACCUM, 0,  1,    2, 24'h00_8000, 1'b0));
    offer_item(mk_item(FUNC_READ,  0,  1,    2, '0,          1'b0));
    wait_idle();
    apply_config(11'h080, 11'h400);                 // channel field reads as zero
    offer_item(mk_item(FUNC_ACCUM, 1,  2,    3, 24'hFF_0000, 1'b0));
    offer_item(mk_item(FUNC_READ,  1,  2,    3, '0,          1'b0));
  endtask

  // phases of hot-bin traffic with some noise, each under its own settings
  task automatic test_random_traffic();
    bin_item_t   hot [4];
    bin_item_t   it;
    int unsigned roll;
    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      case (phase)
        0:       apply_config(11'd64, 11'd1024);
        1:       apply_config(11'd0, 11'd0);
        2:       apply_config(11'h7FF, 11'd1025);
        3:       apply_config(CFG_DAT_W'($urandom_range(1, 8)),
                              CFG_DAT_W'($urandom_range(1, 64)));
        4:       apply_config(CFG_DAT_W'($urandom), CFG_DAT_W'($urandom));
        default: apply_config(11'd3, 11'd100);
      endcase
      foreach (hot[k]) hot[k] = pick_bin();
      for (int n = 0; n < 130; n++) begin
        if (n % 40 == 0) begin
          src_no_idle  = ($urandom_range(0, 3) == 0);
          sink_no_idle = ($urandom_range(0, 3) == 0);
        end
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
          it = mk_item(1'($urandom), $urandom, $urandom, $urandom,
                       VAL_W'($urandom), 1'($urandom));
        end else begin
          it = hot[$urandom_range(0, 3)];
          it.func           = ($urandom_range(0, 3) == 0) ? FUNC_READ : FUNC_ACCUM;
          it.sample_value   = rand_sample();
          it.sample_missing = ($urandom_range(0, 6) == 0);
        end
        if (roll >= 95) hot[$urandom_range(0, 3)] = pick_bin();
        offer_item(it);
      end
    end
    src_no_idle  = 1'b0;
    sink_no_idle = 1'b0;
  endtask

  // receiver stops for a long stretch while beats keep coming back to back
  task automatic test_output_backpressure();
    bin_item_t b;
    bin_item_t it;
    wait_idle();
    apply_config(11'd8, 11'd32);
    b = pick_bin();
    src_no_idle    = 1'b1;
    sink_long_hold = 1'b1;
    for (int n = 0; n < 40; n++) begin
      it = b;
      it.func           = (n % 3 == 0) ? FUNC_READ : FUNC_ACCUM;
      it.sample_value   = rand_sample();
      it.sample_missing = 1'b0;
      offer_item(it);
    end
    src_no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < STORE_DEPTH_DEF; i++) begin
      sum_bank[i] = '0;
      hit_bank[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_corners();
    test_register_clamping();
    test_random_traffic();
    test_output_backpressure();
    wait_idle();

    $display("Sent %0d beats, checked %0d reads (%0d out of range), %0d register writes",
             items_sent, reads_checked, oor_seen, cfg_writes);
    $display("Long receiver hold-offs: %0d, mismatches: %0d", long_holds, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/bsha_pkg.sv
hw/rtl/bsha_ctrl.sv
hw/rtl/bsha_datapath.sv
hw/rtl/binned_sum_and_hit_accumulator.sv
dv/testbench.sv
